FILE: src/dttc_pkg.sv
// ----------------------------------------------------------------------------
// Turn-taking controller package
// Shared types and constants for the controller, the datapath and the top
// level of the full-duplex turn-taking controller.
// ----------------------------------------------------------------------------
package dttc_pkg;

  localparam int TIME_BITS = 48;
  localparam int LAT_BITS = 32;
  localparam int FRAC_BITS = 8;
  localparam int MEAN_W = LAT_BITS + FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(MEAN_W);
  localparam int SIG_W = 2;

  localparam logic [SIG_W-1:0] SIG_YIELD = 2'd1;
  localparam logic [SIG_W-1:0] SIG_BACK = 2'd2;

  typedef enum logic [2:0] {
    REQ_USER,
    REQ_AGENT,
    REQ_SILENCE,
    REQ_START,
    REQ_FIRST,
    REQ_CANCEL,
    REQ_END,
    REQ_FALLBACK
  } req_e;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_USER,
    PH_AGENT,
    PH_OVERLAP,
    PH_BACK
  } phase_e;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_START,
    ACT_CANCEL,
    ACT_FLUSH,
    ACT_BACKCH,
    ACT_YIELD
  } act_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PREP,
    ST_DIV,
    ST_UPD,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic exec;
    logic prep;
    logic div_step;
    logic upd;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
  } dp_sts_t;

endpackage

FILE: src/duplex_turn_taking_controller_top.sv
// ----------------------------------------------------------------------------
// Full-duplex turn-taking controller
// Tracks the floor between a user and an agent over timestamped voice
// events and returns one action and bookkeeping snapshot per event.
// ----------------------------------------------------------------------------
// One request is in work at a time. A first-byte request while streaming
// with more than one output started also runs the bit-serial divider, which
// produces one bit of the 40-bit latency mean correction per cycle. The
// result sits in an output register, so a new request is accepted while the
// previous result waits to be taken.
module duplex_turn_taking_controller_top #(
  parameter int COUNT_BITS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // time_ms[47:0], turn_signal[49:48], fallback_value[50], zero fill above.
  input  logic [55:0]  s_axis_tdata,
  // req_type[2:0].
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // action[2:0], status[3], phase_now[6:4], interrupted[7], streaming_now[8],
  // cancelled_now[9], turn_number[41:10], user_chunk_count[73:42],
  // agent_chunk_count[105:74], interrupt_count[137:106],
  // mean_latency[177:138], output_count[209:178], zero fill above.
  output logic [215:0] m_axis_tdata
);

  dttc_pkg::dp_cmd_t cmd;
  dttc_pkg::dp_sts_t sts;

  logic [2:0] action, phase_now;
  logic status, interrupted, streaming_now, cancelled_now;
  logic [31:0] turn_number, user_cnt, agent_cnt, intr_cnt, out_cnt;
  logic [dttc_pkg::MEAN_W-1:0] mean_latency;

  dttc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dttc_datapath #(
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .in_req_i          (s_axis_tuser),
    .in_time_i         (s_axis_tdata[47:0]),
    .in_sig_i          (s_axis_tdata[49:48]),
    .in_fb_i           (s_axis_tdata[50]),
    .out_action_o      (action),
    .out_status_o      (status),
    .out_phase_o       (phase_now),
    .out_interrupted_o (interrupted),
    .out_streaming_o   (streaming_now),
    .out_cancelled_o   (cancelled_now),
    .out_turn_o        (turn_number),
    .out_user_o        (user_cnt),
    .out_agent_o       (agent_cnt),
    .out_intr_o        (intr_cnt),
    .out_mean_o        (mean_latency),
    .out_outputs_o     (out_cnt)
  );

  assign m_axis_tdata = {6'b0, out_cnt, mean_latency, intr_cnt, agent_cnt, user_cnt,
                         turn_number, cancelled_now, streaming_now, interrupted,
                         phase_now, status, action};

endmodule

FILE: src/dttc_ctrl.sv
// ----------------------------------------------------------------------------
// Turn-taking controller sequencer
// State machine that accepts one request, steps the datapath through the
// event update and the serial mean divide, and hands the result to the
// output register.
// ----------------------------------------------------------------------------
module dttc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  dttc_pkg::dp_sts_t sts_i,
  output dttc_pkg::dp_cmd_t cmd_o
);

  dttc_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dttc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      dttc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = dttc_pkg::ST_EXEC;
        end
      end
      dttc_pkg::ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d = sts_i.need_div ? dttc_pkg::ST_PREP : dttc_pkg::ST_DONE;
      end
      dttc_pkg::ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d = dttc_pkg::ST_DIV;
      end
      dttc_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          state_d = dttc_pkg::ST_UPD;
        end
      end
      dttc_pkg::ST_UPD: begin
        cmd_o.upd = 1'b1;
        state_d = dttc_pkg::ST_DONE;
      end
      dttc_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d = dttc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dttc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == dttc_pkg::ST_EXEC))
    else $error("accepted request did not enter execution");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o))
    else $error("more than one datapath command in a cycle");

  a_upd_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dttc_pkg::ST_UPD) |-> ($past(state_q) == dttc_pkg::ST_DIV))
    else $error("mean update without a finished divide");

  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dttc_pkg::ST_DONE && out_valid_q && !out_ready_i)
      |=> (state_q == dttc_pkg::ST_DONE))
    else $error("result overwrote an unread output");

endmodule

FILE: src/dttc_datapath.sv
// ----------------------------------------------------------------------------
// Turn-taking controller datapath
// Phase and bookkeeping registers, the per-event update, the first-byte
// latency path with its bit-serial divider, and the output register.
// ----------------------------------------------------------------------------
module dttc_datapath #(
  parameter int COUNT_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  dttc_pkg::dp_cmd_t                cmd_i,
  output dttc_pkg::dp_sts_t                sts_o,
  input  logic [2:0]                       in_req_i,
  input  logic [dttc_pkg::TIME_BITS-1:0]   in_time_i,
  input  logic [dttc_pkg::SIG_W-1:0]       in_sig_i,
  input  logic                             in_fb_i,
  output logic [2:0]                       out_action_o,
  output logic                             out_status_o,
  output logic [2:0]                       out_phase_o,
  output logic                             out_interrupted_o,
  output logic                             out_streaming_o,
  output logic                             out_cancelled_o,
  output logic [31:0]                      out_turn_o,
  output logic [31:0]                      out_user_o,
  output logic [31:0]                      out_agent_o,
  output logic [31:0]                      out_intr_o,
  output logic [dttc_pkg::MEAN_W-1:0]      out_mean_o,
  output logic [31:0]                      out_outputs_o
);

  localparam int TB = dttc_pkg::TIME_BITS;
  localparam int MW = dttc_pkg::MEAN_W;
  localparam int CW = dttc_pkg::DIV_CNT_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == CNT_MAX) ? v : v + COUNT_BITS'(1);
  endfunction

  dttc_pkg::req_e req_q;
  logic [TB-1:0] time_q;
  logic [dttc_pkg::SIG_W-1:0] sig_q;
  logic fb_q;

  dttc_pkg::phase_e phase_q, phase_d;
  logic [COUNT_BITS-1:0] turn_q, turn_d;
  logic [COUNT_BITS-1:0] user_q, user_d;
  logic [COUNT_BITS-1:0] agent_q, agent_d;
  logic [COUNT_BITS-1:0] intr_total_q, intr_total_d;
  logic [COUNT_BITS-1:0] outs_q, outs_d;
  logic intr_flag_q, intr_flag_d;
  logic stream_q, stream_d;
  logic cancel_q, cancel_d;
  logic fallback_q, fallback_d;
  logic [TB-1:0] req_time_q, req_time_d;
  logic [MW-1:0] mean_q, mean_d;
  dttc_pkg::act_e act_q, act_d;
  logic status_q, status_d;

  logic [TB:0] tdiff;
  logic [dttc_pkg::LAT_BITS-1:0] lat;
  logic [MW-1:0] latf_c, latf_q;
  logic sign_q;
  logic [COUNT_BITS:0] rem_q, trial;
  logic [MW-1:0] quo_q;
  logic [CW-1:0] cnt_q;
  logic ge;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= dttc_pkg::req_e'(in_req_i);
      time_q <= in_time_i;
      sig_q <= in_sig_i;
      fb_q <= in_fb_i;
    end
  end

  always_comb begin
    tdiff = {1'b0, time_q} - {1'b0, req_time_q};
    if (tdiff[TB]) begin
      lat = '0;
    end else if (|tdiff[TB-1:dttc_pkg::LAT_BITS]) begin
      lat = '1;
    end else begin
      lat = tdiff[dttc_pkg::LAT_BITS-1:0];
    end
    latf_c = MW'(lat) << dttc_pkg::FRAC_BITS;
  end

  assign sts_o.need_div = (req_q == dttc_pkg::REQ_FIRST) && stream_q &&
                          (outs_q > COUNT_BITS'(1));
  assign sts_o.div_done = (cnt_q == CW'(MW - 1));

  always_comb begin
    phase_d = phase_q;
    turn_d = turn_q;
    user_d = user_q;
    agent_d = agent_q;
    intr_total_d = intr_total_q;
    outs_d = outs_q;
    intr_flag_d = intr_flag_q;
    stream_d = stream_q;
    cancel_d = cancel_q;
    fallback_d = fallback_q;
    req_time_d = req_time_q;
    mean_d = mean_q;
    act_d = dttc_pkg::ACT_NONE;
    status_d = 1'b0;
    case (req_q)
      dttc_pkg::REQ_USER: begin
        user_d = sat_inc(user_q);
        if (fallback_q) begin
          if (phase_q == dttc_pkg::PH_AGENT || phase_q == dttc_pkg::PH_OVERLAP) begin
            intr_flag_d = 1'b1;
            intr_total_d = sat_inc(intr_total_q);
            if (stream_q) begin
              cancel_d = 1'b1;
              stream_d = 1'b0;
            end
            act_d = dttc_pkg::ACT_CANCEL;
          end
          phase_d = dttc_pkg::PH_USER;
        end else begin
          case (phase_q)
            dttc_pkg::PH_IDLE: begin
              turn_d = turn_q + COUNT_BITS'(1);
              agent_d = '0;
              user_d = COUNT_BITS'(1);
              if (sig_q == dttc_pkg::SIG_YIELD) begin
                phase_d = dttc_pkg::PH_AGENT;
                act_d = dttc_pkg::ACT_START;
              end else begin
                phase_d = dttc_pkg::PH_USER;
              end
            end
            dttc_pkg::PH_AGENT: begin
              if (sig_q != dttc_pkg::SIG_BACK) begin
                phase_d = dttc_pkg::PH_OVERLAP;
                intr_flag_d = 1'b1;
                intr_total_d = sat_inc(intr_total_q);
                if (stream_q) begin
                  cancel_d = 1'b1;
                  stream_d = 1'b0;
                end
                act_d = dttc_pkg::ACT_CANCEL;
              end
            end
            default: begin
              if (sig_q == dttc_pkg::SIG_YIELD) begin
                phase_d = dttc_pkg::PH_AGENT;
                turn_d = turn_q + COUNT_BITS'(1);
                user_d = '0;
                agent_d = '0;
                act_d = dttc_pkg::ACT_START;
              end
            end
          endcase
        end
      end
      dttc_pkg::REQ_AGENT: begin
        act_d = dttc_pkg::ACT_FLUSH;
        agent_d = sat_inc(agent_q);
        case (phase_q)
          dttc_pkg::PH_IDLE: begin
            phase_d = dttc_pkg::PH_AGENT;
            turn_d = turn_q + COUNT_BITS'(1);
            user_d = '0;
            agent_d = COUNT_BITS'(1);
          end
          dttc_pkg::PH_USER: begin
            if (sig_q == dttc_pkg::SIG_BACK) begin
              phase_d = dttc_pkg::PH_BACK;
              act_d = dttc_pkg::ACT_BACKCH;
            end else begin
              phase_d = dttc_pkg::PH_OVERLAP;
            end
          end
          dttc_pkg::PH_AGENT: begin
            if (sig_q == dttc_pkg::SIG_YIELD) begin
              phase_d = dttc_pkg::PH_IDLE;
              stream_d = 1'b0;
              act_d = dttc_pkg::ACT_YIELD;
            end
          end
          dttc_pkg::PH_OVERLAP: begin
            if (sig_q == dttc_pkg::SIG_YIELD) begin
              phase_d = dttc_pkg::PH_USER;
              turn_d = turn_q + COUNT_BITS'(1);
              user_d = '0;
              agent_d = '0;
              stream_d = 1'b0;
              intr_flag_d = 1'b0;
              act_d = dttc_pkg::ACT_CANCEL;
            end
          end
          default: begin
            if (sig_q == dttc_pkg::SIG_YIELD) begin
              phase_d = dttc_pkg::PH_USER;
              act_d = dttc_pkg::ACT_YIELD;
            end
          end
        endcase
      end
      dttc_pkg::REQ_SILENCE: begin
        if (phase_q == dttc_pkg::PH_USER) begin
          phase_d = dttc_pkg::PH_AGENT;
          turn_d = turn_q + COUNT_BITS'(1);
          user_d = '0;
          agent_d = '0;
          act_d = dttc_pkg::ACT_START;
        end else if (phase_q == dttc_pkg::PH_OVERLAP) begin
          phase_d = dttc_pkg::PH_USER;
          turn_d = turn_q + COUNT_BITS'(1);
          user_d = '0;
          agent_d = '0;
          stream_d = 1'b0;
          act_d = dttc_pkg::ACT_CANCEL;
        end
      end
      dttc_pkg::REQ_START: begin
        req_time_d = time_q;
        stream_d = 1'b1;
        cancel_d = 1'b0;
        outs_d = sat_inc(outs_q);
      end
      dttc_pkg::REQ_FIRST: begin
        if (!stream_q) begin
          status_d = 1'b1;
        end else if (outs_q <= COUNT_BITS'(1)) begin
          mean_d = latf_c;
        end
      end
      dttc_pkg::REQ_CANCEL, dttc_pkg::REQ_END: begin
        if (req_q == dttc_pkg::REQ_CANCEL) begin
          cancel_d = 1'b1;
        end
        stream_d = 1'b0;
        if (phase_q == dttc_pkg::PH_AGENT) begin
          phase_d = dttc_pkg::PH_IDLE;
        end else if (phase_q == dttc_pkg::PH_OVERLAP) begin
          phase_d = dttc_pkg::PH_USER;
        end
      end
      default: begin
        fallback_d = fb_q;
        if (fb_q && phase_q == dttc_pkg::PH_OVERLAP) begin
          phase_d = dttc_pkg::PH_USER;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= dttc_pkg::PH_IDLE;
      turn_q <= '0;
      user_q <= '0;
      agent_q <= '0;
      intr_total_q <= '0;
      outs_q <= '0;
      intr_flag_q <= 1'b0;
      stream_q <= 1'b0;
      cancel_q <= 1'b0;
      fallback_q <= 1'b0;
      req_time_q <= '0;
      mean_q <= '0;
    end else if (cmd_i.exec) begin
      phase_q <= phase_d;
      turn_q <= turn_d;
      user_q <= user_d;
      agent_q <= agent_d;
      intr_total_q <= intr_total_d;
      outs_q <= outs_d;
      intr_flag_q <= intr_flag_d;
      stream_q <= stream_d;
      cancel_q <= cancel_d;
      fallback_q <= fallback_d;
      req_time_q <= req_time_d;
      mean_q <= mean_d;
    end else if (cmd_i.upd) begin
      mean_q <= sign_q ? (mean_q + quo_q) : (mean_q - quo_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      act_q <= act_d;
      status_q <= status_d;
      latf_q <= latf_c;
    end
  end

  // Restoring divide, one quotient bit per cycle; the dividend shifts out of
  // the top of quo_q as the quotient shifts in at the bottom.
  assign trial = {rem_q[COUNT_BITS-1:0], quo_q[MW-1]};
  assign ge = (trial >= {1'b0, outs_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      sign_q <= (latf_q >= mean_q);
      quo_q <= (latf_q >= mean_q) ? (latf_q - mean_q) : (mean_q - latf_q);
      rem_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? (trial - {1'b0, outs_q}) : trial;
      quo_q <= {quo_q[MW-2:0], ge};
      cnt_q <= cnt_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_action_o <= act_q;
      out_status_o <= status_q;
      out_phase_o <= phase_q;
      out_interrupted_o <= (phase_q == dttc_pkg::PH_OVERLAP) || intr_flag_q;
      out_streaming_o <= stream_q;
      out_cancelled_o <= cancel_q;
      out_turn_o <= 32'(turn_q);
      out_user_o <= 32'(user_q);
      out_agent_o <= 32'(agent_q);
      out_intr_o <= 32'(intr_total_q);
      out_mean_o <= mean_q;
      out_outputs_o <= 32'(outs_q);
    end
  end

endmodule

FILE: tb/tb_duplex_turn_taking_controller_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Turn-taking controller testbench
// Drives timestamped voice events into the controller through the request
// stream. A predictor of the floor logic runs alongside and works out the
// snapshot that each request should return, and every returned snapshot is
// compared field by field. The run goes through directed corner cases,
// randomized dialogues under changing stall patterns, and a long receiver
// hold-off.
// ----------------------------------------------------------------------------
module tb_duplex_turn_taking_controller_top;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLDOFF_CYCLES = 300;

  typedef struct packed {
    dttc_pkg::act_e   action;
    logic             status;
    dttc_pkg::phase_e phase;
    logic             interrupted;
    logic             streaming;
    logic             cancelled;
    logic [31:0]      turn;
    logic [31:0]      user_count;
    logic [31:0]      agent_count;
    logic [31:0]      interrupts;
    logic [39:0]      mean_latency;
    logic [31:0]      outputs;
  } floor_snapshot_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [55:0]  s_axis_tdata = '0;
  logic [2:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [215:0] m_axis_tdata;

  floor_snapshot_t pending_snapshots[$];
  int unsigned     send_idle_pct = 0;
  int unsigned     recv_idle_pct = 0;
  int unsigned     requests_sent = 0;
  int unsigned     mismatch_count = 0;
  int unsigned     quiet_cycles = 0;
  int unsigned     holdoff_left = 0;
  logic            holdoff_go = 1'b0;
  logic            holdoff_armed = 1'b0;
  logic [47:0]     now_ms = '0;

  // Predicted controller state.
  dttc_pkg::phase_e ph;
  logic [31:0]      turn_ctr;
  logic [31:0]      user_cnt;
  logic [31:0]      agent_cnt;
  logic [31:0]      intr_total;
  logic [31:0]      outputs_total;
  logic             intr_flag;
  logic             strm_flag;
  logic             canc_flag;
  logic             fb_flag;
  logic [47:0]      req_time;
  logic [39:0]      lat_mean;

  duplex_turn_taking_controller_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  function automatic void reset_floor_state();
    ph = dttc_pkg::PH_IDLE;
    turn_ctr = '0;
    user_cnt = '0;
    agent_cnt = '0;
    intr_total = '0;
    outputs_total = '0;
    intr_flag = 1'b0;
    strm_flag = 1'b0;
    canc_flag = 1'b0;
    fb_flag = 1'b0;
    req_time = '0;
    lat_mean = '0;
  endfunction

  function automatic void open_turn();
    turn_ctr = turn_ctr + 32'd1;
    user_cnt = '0;
    agent_cnt = '0;
  endfunction

  function automatic void mark_interrupt();
    intr_flag = 1'b1;
    intr_total = sat_inc(intr_total);
    if (strm_flag) begin
      canc_flag = 1'b1;
      strm_flag = 1'b0;
    end
  endfunction

  function automatic void stop_output();
    strm_flag = 1'b0;
    if (ph == dttc_pkg::PH_AGENT) begin
      ph = dttc_pkg::PH_IDLE;
    end else if (ph == dttc_pkg::PH_OVERLAP) begin
      ph = dttc_pkg::PH_USER;
    end
  endfunction

  function automatic floor_snapshot_t advance_floor(dttc_pkg::req_e req, logic [47:0] t,
                                                    logic [1:0] sig, logic fb);
    floor_snapshot_t snap;
    dttc_pkg::act_e  act;
    logic            status;
    logic [47:0]     gap;
    logic [39:0]     latf;
    logic [39:0]     n;
    act = dttc_pkg::ACT_NONE;
    status = 1'b0;
    case (req)
      dttc_pkg::REQ_USER: begin
        user_cnt = sat_inc(user_cnt);
        if (fb_flag) begin
          if (ph == dttc_pkg::PH_AGENT || ph == dttc_pkg::PH_OVERLAP) begin
            mark_interrupt();
            act = dttc_pkg::ACT_CANCEL;
          end
          ph = dttc_pkg::PH_USER;
        end else begin
          case (ph)
            dttc_pkg::PH_IDLE: begin
              ph = dttc_pkg::PH_USER;
              open_turn();
              user_cnt = 32'd1;
              if (sig == dttc_pkg::SIG_YIELD) begin
                ph = dttc_pkg::PH_AGENT;
                act = dttc_pkg::ACT_START;
              end
            end
            dttc_pkg::PH_AGENT: begin
              if (sig != dttc_pkg::SIG_BACK) begin
                ph = dttc_pkg::PH_OVERLAP;
                mark_interrupt();
                act = dttc_pkg::ACT_CANCEL;
              end
            end
            default: begin
              if (sig == dttc_pkg::SIG_YIELD) begin
                ph = dttc_pkg::PH_AGENT;
                open_turn();
                act = dttc_pkg::ACT_START;
              end
            end
          endcase
        end
      end
      dttc_pkg::REQ_AGENT: begin
        act = dttc_pkg::ACT_FLUSH;
        agent_cnt = sat_inc(agent_cnt);
        case (ph)
          dttc_pkg::PH_IDLE: begin
            ph = dttc_pkg::PH_AGENT;
            open_turn();
            agent_cnt = 32'd1;
          end
          dttc_pkg::PH_USER: begin
            if (sig == dttc_pkg::SIG_BACK) begin
              ph = dttc_pkg::PH_BACK;
              act = dttc_pkg::ACT_BACKCH;
            end else begin
              ph = dttc_pkg::PH_OVERLAP;
            end
          end
          dttc_pkg::PH_AGENT: begin
            if (sig == dttc_pkg::SIG_YIELD) begin
              ph = dttc_pkg::PH_IDLE;
              strm_flag = 1'b0;
              act = dttc_pkg::ACT_YIELD;
            end
          end
          dttc_pkg::PH_OVERLAP: begin
            if (sig == dttc_pkg::SIG_YIELD) begin
              ph = dttc_pkg::PH_USER;
              open_turn();
              strm_flag = 1'b0;
              intr_flag = 1'b0;
              act = dttc_pkg::ACT_CANCEL;
            end
          end
          default: begin
            if (sig == dttc_pkg::SIG_YIELD) begin
              ph = dttc_pkg::PH_USER;
              act = dttc_pkg::ACT_YIELD;
            end
          end
        endcase
      end
      dttc_pkg::REQ_SILENCE: begin
        if (ph == dttc_pkg::PH_USER) begin
          ph = dttc_pkg::PH_AGENT;
          open_turn();
          act = dttc_pkg::ACT_START;
        end else if (ph == dttc_pkg::PH_OVERLAP) begin
          ph = dttc_pkg::PH_USER;
          open_turn();
          strm_flag = 1'b0;
          act = dttc_pkg::ACT_CANCEL;
        end
      end
      dttc_pkg::REQ_START: begin
        req_time = t;
        strm_flag = 1'b1;
        canc_flag = 1'b0;
        outputs_total = sat_inc(outputs_total);
      end
      dttc_pkg::REQ_FIRST: begin
        if (strm_flag) begin
          gap = (t >= req_time) ? t - req_time : '0;
          if (gap > 48'hFFFF_FFFF) begin
            gap = 48'hFFFF_FFFF;
          end
          latf = {gap[31:0], 8'd0};
          n = {8'd0, outputs_total};
          if (n <= 40'd1) begin
            lat_mean = latf;
          end else if (latf >= lat_mean) begin
            lat_mean = lat_mean + (latf - lat_mean) / n;
          end else begin
            lat_mean = lat_mean - (lat_mean - latf) / n;
          end
        end else begin
          status = 1'b1;
        end
      end
      dttc_pkg::REQ_CANCEL: begin
        canc_flag = 1'b1;
        stop_output();
      end
      dttc_pkg::REQ_END: begin
        stop_output();
      end
      default: begin
        fb_flag = fb;
        if (fb && ph == dttc_pkg::PH_OVERLAP) begin
          ph = dttc_pkg::PH_USER;
        end
      end
    endcase
    snap.action = act;
    snap.status = status;
    snap.phase = ph;
    snap.interrupted = (ph == dttc_pkg::PH_OVERLAP) || intr_flag;
    snap.streaming = strm_flag;
    snap.cancelled = canc_flag;
    snap.turn = turn_ctr;
    snap.user_count = user_cnt;
    snap.agent_count = agent_cnt;
    snap.interrupts = intr_total;
    snap.mean_latency = lat_mean;
    snap.outputs = outputs_total;
    return snap;
  endfunction

  function automatic logic [47:0] next_time();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 2) begin
      now_ms = 48'({$urandom, $urandom});
    end else if (pick < 5) begin
      now_ms = now_ms + {16'd0, $urandom} + 48'h1_0000_0000;
    end else begin
      now_ms = now_ms + 48'($urandom_range(0, 1500));
    end
    return now_ms;
  endfunction

  function automatic logic [1:0] plain_signal();
    logic [1:0] s;
    s = 2'($urandom_range(0, 2));
    return (s == dttc_pkg::SIG_YIELD) ? 2'd3 : s;
  endfunction

  task automatic send_request(dttc_pkg::req_e req, logic [47:0] t, logic [1:0] sig,
                              logic fb);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'd0, fb, sig, t};
    s_axis_tuser <= req;
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
    pending_snapshots.push_back(advance_floor(req, t, sig, fb));
    requests_sent++;
  endtask

  task automatic send_event(dttc_pkg::req_e req, logic [1:0] sig);
    send_request(req, next_time(), sig, 1'b0);
  endtask

  task automatic compare_field(string name, logic [39:0] want, logic [39:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t ns: %s expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  task automatic check_snapshot(logic [215:0] d);
    floor_snapshot_t want;
    if (pending_snapshots.size() == 0) begin
      mismatch_count++;
      $display("%0t ns: unexpected result, expected none, actual 0x%0h", $time, d);
    end else begin
      want = pending_snapshots.pop_front();
      compare_field("action", 40'(want.action), 40'(d[2:0]));
      compare_field("status", 40'(want.status), 40'(d[3]));
      compare_field("phase_now", 40'(want.phase), 40'(d[6:4]));
      compare_field("interrupted", 40'(want.interrupted), 40'(d[7]));
      compare_field("streaming_now", 40'(want.streaming), 40'(d[8]));
      compare_field("cancelled_now", 40'(want.cancelled), 40'(d[9]));
      compare_field("turn_number", 40'(want.turn), 40'(d[41:10]));
      compare_field("user_chunk_count", 40'(want.user_count), 40'(d[73:42]));
      compare_field("agent_chunk_count", 40'(want.agent_count), 40'(d[105:74]));
      compare_field("interrupt_count", 40'(want.interrupts), 40'(d[137:106]));
      compare_field("mean_latency", want.mean_latency, d[177:138]);
      compare_field("output_count", 40'(want.outputs), 40'(d[209:178]));
    end
  endtask

  always @(negedge clk_i) begin
    if (holdoff_go && !holdoff_armed) begin
      holdoff_left = HOLDOFF_CYCLES;
      holdoff_armed = 1'b1;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      check_snapshot(m_axis_tdata);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no request or result moved for %0d cycles", $time, quiet_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic test_floor_corner_cases();
    send_request(dttc_pkg::REQ_FIRST, 48'd0, 2'd0, 1'b0);
    send_request(dttc_pkg::REQ_USER, 48'd10, 2'd0, 1'b0);
    send_request(dttc_pkg::REQ_AGENT, 48'd20, dttc_pkg::SIG_BACK, 1'b0);
    send_request(dttc_pkg::REQ_AGENT, 48'd30, dttc_pkg::SIG_YIELD, 1'b0);
    send_request(dttc_pkg::REQ_USER, 48'd40, dttc_pkg::SIG_YIELD, 1'b0);
    send_request(dttc_pkg::REQ_START, 48'd50, 2'd0, 1'b0);
    send_request(dttc_pkg::REQ_FIRST, 48'd40, 2'd0, 1'b0);
    send_request(dttc_pkg::REQ_AGENT, 48'd60, 2'd3, 1'b0);
    send_request(dttc_pkg::REQ_USER, 48'd70, 2'd3, 1'b0);
    send_request(dttc_pkg::REQ_SILENCE, 48'd80, 2'd0, 1'b0);
    send_request(dttc_pkg::REQ_SILENCE, 48'd90, 2'd0, 1'b0);
    send_request(dttc_pkg::REQ_START, 48'd100, 2'd0, 1'b0);
    send_request(dttc_pkg::REQ_START, 48'd110, 2'd0, 1'b0);
    send_request(dttc_pkg::REQ_FIRST, 48'h8000_0000_0000, 2'd0, 1'b0);
    send_request(dttc_pkg::REQ_FIRST, 48'hFFFF_FFFF_FFFF, 2'd3, 1'b1);
    send_request(dttc_pkg::REQ_START, 48'hFFFF_FFFF_FFFF, 2'd0, 1'b0);
    send_request(dttc_pkg::REQ_FIRST, 48'hFFFF_FFFF_FFFF, 2'd0, 1'b0);
    send_request(dttc_pkg::REQ_USER, 48'd200, dttc_pkg::SIG_BACK, 1'b0);
    send_request(dttc_pkg::REQ_AGENT, 48'd210, dttc_pkg::SIG_YIELD, 1'b0);
    send_request(dttc_pkg::REQ_FALLBACK, 48'd220, 2'd0, 1'b1);
    send_request(dttc_pkg::REQ_AGENT, 48'd230, 2'd0, 1'b0);
    send_request(dttc_pkg::REQ_USER, 48'd240, 2'd0, 1'b0);
    send_request(dttc_pkg::REQ_CANCEL, 48'd250, 2'd0, 1'b0);
    send_request(dttc_pkg::REQ_END, 48'd260, 2'd0, 1'b0);
    send_request(dttc_pkg::REQ_FALLBACK, 48'd270, 2'd0, 1'b0);
    now_ms = 48'd300;
  endtask

  // One exchange: the user talks and hands over, the agent streams an answer,
  // and the turn ends by a yield, a barge-in, a cancel or an end of output.
  task automatic run_exchange();
    int unsigned k;
    logic        in_fallback;
    in_fallback = ($urandom_range(0, 7) == 0);
    if (in_fallback) begin
      send_request(dttc_pkg::REQ_FALLBACK, next_time(), plain_signal(), 1'b1);
    end
    k = $urandom_range(0, 4);
    repeat (k) send_event(dttc_pkg::REQ_USER, plain_signal());
    if ($urandom_range(0, 1) == 0) begin
      send_event(dttc_pkg::REQ_USER, dttc_pkg::SIG_YIELD);
    end else begin
      send_event(dttc_pkg::REQ_SILENCE, plain_signal());
    end
    send_event(dttc_pkg::REQ_START, plain_signal());
    if ($urandom_range(0, 9) != 0) begin
      send_event(dttc_pkg::REQ_FIRST, plain_signal());
    end
    k = $urandom_range(0, 5);
    repeat (k) begin
      if ($urandom_range(0, 4) == 0) begin
        send_event(dttc_pkg::REQ_USER, dttc_pkg::SIG_BACK);
      end else begin
        send_event(dttc_pkg::REQ_AGENT, plain_signal());
      end
    end
    case ($urandom_range(0, 4))
      0: send_event(dttc_pkg::REQ_AGENT, dttc_pkg::SIG_YIELD);
      1: begin
        send_event(dttc_pkg::REQ_USER, plain_signal());
        if ($urandom_range(0, 1) == 0) begin
          send_event(dttc_pkg::REQ_SILENCE, plain_signal());
        end else begin
          send_event(dttc_pkg::REQ_AGENT, plain_signal());
          send_event(dttc_pkg::REQ_AGENT, dttc_pkg::SIG_YIELD);
        end
      end
      2: send_event(dttc_pkg::REQ_CANCEL, plain_signal());
      3: send_event(dttc_pkg::REQ_END, plain_signal());
      default: begin
        send_event(dttc_pkg::REQ_USER, plain_signal());
        send_event(dttc_pkg::REQ_END, plain_signal());
      end
    endcase
    if (in_fallback) begin
      send_request(dttc_pkg::REQ_FALLBACK, next_time(), plain_signal(), 1'b0);
    end
  endtask

  task automatic test_random_dialogue(int unsigned count);
    int unsigned goal;
    goal = requests_sent + count;
    while (requests_sent < goal) begin
      if ($urandom_range(0, 99) < 20) begin
        send_request(dttc_pkg::req_e'($urandom_range(0, 7)), next_time(),
                     2'($urandom_range(0, 3)), ($urandom_range(0, 3) == 0));
      end else begin
        run_exchange();
      end
    end
  endtask

  task automatic test_output_backpressure();
    holdoff_go = 1'b1;
    repeat (6) begin
      send_event(dttc_pkg::REQ_START, 2'd0);
      send_event(dttc_pkg::REQ_FIRST, 2'd0);
      send_event(dttc_pkg::REQ_AGENT, plain_signal());
      send_event(dttc_pkg::REQ_USER, plain_signal());
      send_event(dttc_pkg::REQ_END, 2'd0);
    end
  endtask

  initial begin
    reset_floor_state();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_floor_corner_cases();
    send_idle_pct = 18;
    recv_idle_pct = 63;
    test_random_dialogue(470);
    send_idle_pct = 63;
    recv_idle_pct = 18;
    test_random_dialogue(470);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_output_backpressure();
    test_random_dialogue(450);

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_snapshots.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
